// ===== hw/rtl/lcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Load-cell position conditioner package
// Channel count, configuration register indexes, reset values and phase codes.
// ----------------------------------------------------------------------------
package lcpc_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W = $clog2(CHANNELS);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_B0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_B1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd6;

    // Register reset values
    localparam logic [15:0]        SKIP_COUNT_RST = 16'd400;
    localparam logic [3:0]         CAL_SHIFT_RST  = 4'd9;
    localparam logic signed [17:0] COEFF_B0_RST   = 18'sd4784;
    localparam logic signed [17:0] COEFF_B1_RST   = 18'sd4784;
    localparam logic signed [17:0] COEFF_A1_RST   = -18'sd55974;
    localparam logic [15:0]        GAIN_RST       = 16'd1311;
    localparam logic [30:0]        DEADBAND_RST   = 31'd1311;

    // Largest usable baseline averaging shift.
    localparam logic [3:0] CAL_SHIFT_MAX = 4'd12;

    // 0.2 in Q2.16
    localparam logic signed [17:0] POINT_TWO_Q16 = 18'sd13107;

    localparam int POS_FRAC = 16;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_CAL,
        PH_RUN
    } phase_t;

endpackage

// ===== hw/rtl/load_cell_position_conditioner.sv =====
// ----------------------------------------------------------------------------
// Load-cell position conditioner
// Skip line: straight to DONE. Calibration line: CAL_ACC per channel, then CAL_BASE
// per channel on the line that closes calibration. Run line: RUN_MAC and RUN_FIN per
// channel, then POS_SCALE, POS_GAIN and POS_HOLD, on one shared 18xN multiplier
// doing three filter products per channel plus two position products; then DONE.
// One line at a time; rst_n clears phase, counters, held position and registers.
// ----------------------------------------------------------------------------
module load_cell_position_conditioner
    import lcpc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_FRAC = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // Sample channel
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] chan0,
    input  logic signed [SAMPLE_BITS-1:0] chan1,
    input  logic signed [SAMPLE_BITS-1:0] chan2,
    input  logic signed [SAMPLE_BITS-1:0] chan3,
    input  logic signed [SAMPLE_BITS-1:0] chan4,
    input  logic signed [SAMPLE_BITS-1:0] chan5,
    input  logic signed [SAMPLE_BITS-1:0] chan6,
    input  logic signed [SAMPLE_BITS-1:0] chan7,
    // Result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic signed [SAMPLE_BITS:0]   dev0,
    output logic signed [SAMPLE_BITS:0]   dev1,
    output logic signed [SAMPLE_BITS:0]   dev2,
    output logic signed [SAMPLE_BITS:0]   dev3,
    output logic signed [SAMPLE_BITS:0]   dev4,
    output logic signed [SAMPLE_BITS:0]   dev5,
    output logic signed [SAMPLE_BITS:0]   dev6,
    output logic signed [SAMPLE_BITS:0]   dev7,
    output logic signed [31:0]            pos_lateral,
    output logic                          run_valid,
    output logic                          calibrating
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SB + 1;                        // deviation width
    localparam int BW = SB + 13;                       // calibration sum and baseline
    localparam int YW = (BW > 32) ? BW : 32;           // filter output state
    localparam int MW = (SB + 16 > 32) ? SB + 16 : 32; // wide multiplier operand
    localparam int PW = MW + 18;                       // product
    localparam int AW = MW + 20;                       // accumulator

    localparam logic signed [AW-1:0] ROUND_F =
        {{(AW-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic signed [AW-1:0] ROUND_P =
        {{(AW-POS_FRAC){1'b0}}, 1'b1, {(POS_FRAC-1){1'b0}}};
    localparam logic signed [AW-1:0] S32_MAX = {{(AW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [AW-1:0] S32_MIN = {{(AW-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [YW:0] DEV_MAX = {{(YW-SB+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [YW:0] DEV_MIN = {{(YW-SB+1){1'b1}}, {(DW-1){1'b0}}};

    typedef enum logic [3:0] {
        IDLE,
        CAL_ACC,
        CAL_BASE,
        RUN_MAC,
        RUN_FIN,
        POS_SCALE,
        POS_GAIN,
        POS_HOLD,
        DONE
    } state_t;

    // Configuration registers
    logic [15:0]        skip_count_reg;
    logic [3:0]         cal_shift_reg;
    logic signed [17:0] coeff_b0_reg;
    logic signed [17:0] coeff_b1_reg;
    logic signed [17:0] coeff_a1_reg;
    logic [15:0]        gain_reg;
    logic [30:0]        deadband_reg;

    // Control
    state_t              state_reg;
    phase_t              phase_reg;
    logic [15:0]         count_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [1:0]          step_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [31:0]  held_reg;
    logic signed [31:0]  pos_work_reg;
    logic                run_work_reg;
    logic                cal_work_reg;
    logic                clear_sum_reg;

    // Per-channel storage
    logic signed [SB-1:0] x_reg        [CHANNELS];
    logic signed [BW-1:0] cal_sum_reg  [CHANNELS];
    logic signed [BW-1:0] base_reg     [CHANNELS];
    logic signed [BW-1:0] pin_reg      [CHANNELS];
    logic signed [YW-1:0] pout_reg     [CHANNELS];
    logic signed [DW-1:0] dev_work_reg [CHANNELS];

    // Result registers
    logic                 result_valid_reg;
    logic signed [DW-1:0] dev_out_reg [CHANNELS];
    logic signed [31:0]   pos_out_reg;
    logic                 run_out_reg;
    logic                 cal_out_reg;

    logic signed [SB-1:0] chan_in [CHANNELS];

    // Datapath
    logic signed [SB-1:0] x_cur;
    logic signed [17:0]   mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] prod_ext;
    logic signed [AW-1:0] y_shift;
    logic signed [31:0]   y_sat;
    logic signed [YW:0]   dev_full;
    logic signed [DW-1:0] dev_sat;
    logic signed [SB+1:0] pos_diff;
    logic signed [AW-1:0] p_shift;
    logic signed [31:0]   p_sat;
    logic signed [32:0]   p_delta;
    logic [32:0]          p_delta_abs;
    logic                 p_move;
    logic [3:0]           s_eff;
    logic signed [BW-1:0] base_half;
    logic signed [BW-1:0] base_new;
    logic [15:0]          count_inc;
    logic                 cal_done;
    logic                 sample_xfer;
    logic                 out_free;

    assign chan_in[0] = chan0;
    assign chan_in[1] = chan1;
    assign chan_in[2] = chan2;
    assign chan_in[3] = chan3;
    assign chan_in[4] = chan4;
    assign chan_in[5] = chan5;
    assign chan_in[6] = chan6;
    assign chan_in[7] = chan7;

    assign sample_stall = (state_reg != IDLE);
    assign sample_xfer  = sample_valid && !sample_stall;
    assign out_free     = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign dev0 = dev_out_reg[0];
    assign dev1 = dev_out_reg[1];
    assign dev2 = dev_out_reg[2];
    assign dev3 = dev_out_reg[3];
    assign dev4 = dev_out_reg[4];
    assign dev5 = dev_out_reg[5];
    assign dev6 = dev_out_reg[6];
    assign dev7 = dev_out_reg[7];
    assign pos_lateral = pos_out_reg;
    assign run_valid   = run_out_reg;
    assign calibrating = cal_out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= SKIP_COUNT_RST;
            cal_shift_reg  <= CAL_SHIFT_RST;
            coeff_b0_reg   <= COEFF_B0_RST;
            coeff_b1_reg   <= COEFF_B1_RST;
            coeff_a1_reg   <= COEFF_A1_RST;
            gain_reg       <= GAIN_RST;
            deadband_reg   <= DEADBAND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SKIP_COUNT: skip_count_reg <= cfg_data[15:0];
                CFG_CAL_SHIFT:  cal_shift_reg  <= cfg_data[3:0];
                CFG_COEFF_B0:   coeff_b0_reg   <= signed'(cfg_data[17:0]);
                CFG_COEFF_B1:   coeff_b1_reg   <= signed'(cfg_data[17:0]);
                CFG_COEFF_A1:   coeff_a1_reg   <= signed'(cfg_data[17:0]);
                CFG_GAIN:       gain_reg       <= cfg_data[15:0];
                CFG_DEADBAND:   deadband_reg   <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // Shared multiplier operand selection and the narrow post-processing paths.
    always_comb
    begin
        x_cur = x_reg[ch_reg];
        pos_diff = {dev_work_reg[1][DW-1], dev_work_reg[1]}
                 - {dev_work_reg[0][DW-1], dev_work_reg[0]};

        mul_a = coeff_b0_reg;
        mul_b = {{(MW-SB){x_cur[SB-1]}}, x_cur};
        case (state_reg)
            RUN_MAC:
            begin
                case (step_reg)
                    2'd1:
                    begin
                        mul_a = coeff_b1_reg;
                        mul_b = {{(MW-BW){pin_reg[ch_reg][BW-1]}}, pin_reg[ch_reg]};
                    end
                    2'd2:
                    begin
                        mul_a = coeff_a1_reg;
                        mul_b = {{(MW-YW){pout_reg[ch_reg][YW-1]}}, pout_reg[ch_reg]};
                    end
                    default:
                    begin
                        mul_a = coeff_b0_reg;
                        mul_b = {{(MW-SB){x_cur[SB-1]}}, x_cur};
                    end
                endcase
            end
            POS_SCALE:
            begin
                mul_a = POINT_TWO_Q16;
                mul_b = {{(MW-SB-2){pos_diff[SB+1]}}, pos_diff};
            end
            POS_GAIN:
            begin
                mul_a = signed'({2'b00, gain_reg});
                mul_b = acc_reg[MW-1:0];
            end
            default:
            begin
                mul_a = coeff_b0_reg;
                mul_b = {{(MW-SB){x_cur[SB-1]}}, x_cur};
            end
        endcase

        prod = mul_a * mul_b;
        prod_ext = {{(AW-PW){prod[PW-1]}}, prod};

        // Filter output: round half up, saturate to 32 bits.
        y_shift = (acc_reg + ROUND_F) >>> COEF_FRAC;
        if (y_shift > S32_MAX)
        begin
            y_sat = 32'sh7FFF_FFFF;
        end
        else if (y_shift < S32_MIN)
        begin
            y_sat = -32'sh8000_0000;
        end
        else
        begin
            y_sat = y_shift[31:0];
        end

        dev_full = {{(YW-31){y_sat[31]}}, y_sat}
                 - {{(YW+1-BW){base_reg[ch_reg][BW-1]}}, base_reg[ch_reg]};
        if (dev_full > DEV_MAX)
        begin
            dev_sat = DEV_MAX[DW-1:0];
        end
        else if (dev_full < DEV_MIN)
        begin
            dev_sat = DEV_MIN[DW-1:0];
        end
        else
        begin
            dev_sat = dev_full[DW-1:0];
        end

        // Position: round half up, saturate, then the deadband compare.
        p_shift = (acc_reg + ROUND_P) >>> POS_FRAC;
        if (p_shift > S32_MAX)
        begin
            p_sat = 32'sh7FFF_FFFF;
        end
        else if (p_shift < S32_MIN)
        begin
            p_sat = -32'sh8000_0000;
        end
        else
        begin
            p_sat = p_shift[31:0];
        end
        p_delta = {p_sat[31], p_sat} - {held_reg[31], held_reg};
        p_delta_abs = p_delta[32] ? unsigned'(-p_delta) : unsigned'(p_delta);
        p_move = p_delta_abs > {2'b00, deadband_reg};

        // Baseline mean with rounding half up.
        s_eff = (cal_shift_reg > CAL_SHIFT_MAX) ? CAL_SHIFT_MAX : cal_shift_reg;
        if (s_eff == 4'd0)
        begin
            base_half = '0;
        end
        else
        begin
            base_half = {{(BW-1){1'b0}}, 1'b1} << (s_eff - 4'd1);
        end
        base_new = (cal_sum_reg[ch_reg] + base_half) >>> s_eff;

        count_inc = count_reg + 16'd1;
        cal_done = count_inc >= (16'd1 << s_eff);
    end

    // Sequencer, phase tracking and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            phase_reg        <= PH_SKIP;
            count_reg        <= '0;
            ch_reg           <= '0;
            step_reg         <= '0;
            acc_reg          <= '0;
            held_reg         <= '0;
            pos_work_reg     <= '0;
            run_work_reg     <= 1'b0;
            cal_work_reg     <= 1'b0;
            clear_sum_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            pos_out_reg      <= '0;
            run_out_reg      <= 1'b0;
            cal_out_reg      <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                dev_out_reg[i] <= '0;
            end
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (sample_xfer)
                    begin
                        ch_reg        <= '0;
                        step_reg      <= '0;
                        run_work_reg  <= 1'b0;
                        cal_work_reg  <= 1'b0;
                        clear_sum_reg <= 1'b0;
                        case (phase_reg)
                            PH_SKIP:
                            begin
                                cal_work_reg <= 1'b1;
                                if (count_reg >= skip_count_reg)
                                begin
                                    // This line already opens calibration.
                                    phase_reg     <= PH_CAL;
                                    count_reg     <= '0;
                                    clear_sum_reg <= 1'b1;
                                    state_reg     <= CAL_ACC;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 16'd1;
                                    state_reg <= DONE;
                                end
                            end
                            PH_CAL:
                            begin
                                cal_work_reg <= 1'b1;
                                state_reg    <= CAL_ACC;
                            end
                            PH_RUN:
                            begin
                                run_work_reg <= 1'b1;
                                state_reg    <= RUN_MAC;
                            end
                            default:
                            begin
                                state_reg <= DONE;
                            end
                        endcase
                    end
                end

                CAL_ACC:
                begin
                    if (ch_reg == CH_LAST)
                    begin
                        ch_reg        <= '0;
                        clear_sum_reg <= 1'b0;
                        if (cal_done)
                        begin
                            count_reg <= '0;
                            state_reg <= CAL_BASE;
                        end
                        else
                        begin
                            count_reg <= count_inc;
                            state_reg <= DONE;
                        end
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end

                CAL_BASE:
                begin
                    if (ch_reg == CH_LAST)
                    begin
                        ch_reg    <= '0;
                        phase_reg <= PH_RUN;
                        state_reg <= DONE;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end

                RUN_MAC:
                begin
                    case (step_reg)
                        2'd0:
                        begin
                            acc_reg  <= prod_ext;
                            step_reg <= 2'd1;
                        end
                        2'd1:
                        begin
                            acc_reg  <= acc_reg + prod_ext;
                            step_reg <= 2'd2;
                        end
                        default:
                        begin
                            // The feedback term is subtracted.
                            acc_reg   <= acc_reg - prod_ext;
                            step_reg  <= 2'd0;
                            state_reg <= RUN_FIN;
                        end
                    endcase
                end

                RUN_FIN:
                begin
                    if (ch_reg == CH_LAST)
                    begin
                        ch_reg    <= '0;
                        state_reg <= POS_SCALE;
                    end
                    else
                    begin
                        ch_reg    <= ch_reg + 1'b1;
                        state_reg <= RUN_MAC;
                    end
                end

                POS_SCALE:
                begin
                    acc_reg   <= prod_ext;
                    state_reg <= POS_GAIN;
                end

                POS_GAIN:
                begin
                    acc_reg   <= prod_ext;
                    state_reg <= POS_HOLD;
                end

                POS_HOLD:
                begin
                    if (p_move)
                    begin
                        held_reg     <= p_sat;
                        pos_work_reg <= p_sat;
                    end
                    else
                    begin
                        pos_work_reg <= held_reg;
                    end
                    state_reg <= DONE;
                end

                DONE:
                begin
                    if (out_free)
                    begin
                        for (int i = 0; i < CHANNELS; i++)
                        begin
                            dev_out_reg[i] <= run_work_reg ? dev_work_reg[i] : '0;
                        end
                        pos_out_reg      <= run_work_reg ? pos_work_reg : '0;
                        run_out_reg      <= run_work_reg;
                        cal_out_reg      <= cal_work_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= IDLE;
                    end
                end

                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // Per-channel sample and filter storage; every entry is written before it is read.
    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                x_reg[i] <= chan_in[i];
            end
        end

        case (state_reg)
            CAL_ACC:
            begin
                if (clear_sum_reg)
                begin
                    cal_sum_reg[ch_reg] <= {{(BW-SB){x_cur[SB-1]}}, x_cur};
                end
                else
                begin
                    cal_sum_reg[ch_reg] <= cal_sum_reg[ch_reg]
                                         + {{(BW-SB){x_cur[SB-1]}}, x_cur};
                end
            end
            CAL_BASE:
            begin
                base_reg[ch_reg] <= base_new;
                pin_reg[ch_reg]  <= base_new;
                pout_reg[ch_reg] <= {{(YW-BW){base_new[BW-1]}}, base_new};
            end
            RUN_FIN:
            begin
                pin_reg[ch_reg]      <= {{(BW-SB){x_cur[SB-1]}}, x_cur};
                pout_reg[ch_reg]     <= {{(YW-32){y_sat[31]}}, y_sat};
                dev_work_reg[ch_reg] <= dev_sat;
            end
            default:
            begin
            end
        endcase
    end

    // Checks
    a_phase_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(run_valid && calibrating))
        else $error("run and calibration flags both set on a result");

    a_idle_results_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !run_valid) |-> (pos_lateral == '0 && dev0 == '0 && dev1 == '0))
        else $error("result outside run phase carries nonzero data");

    a_run_phase_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RUN) |=> (phase_reg == PH_RUN))
        else $error("left the run phase");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> (state_reg != IDLE))
        else $error("sequencer idle right after a sample transfer");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Load-cell position conditioner testbench
// Drives sample lines through the skip, calibration and run phases and checks
// every result against a line-by-line predictor of the conditioner, under
// random sender bursts, receiver stalls and a sweep of filter settings.
// ----------------------------------------------------------------------------
module testbench;
    import lcpc_pkg::*;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_FRAC = 16;
    localparam int DEV_W = SAMPLE_BITS + 1;
    localparam int SAMPLE_HI = 8388607;
    localparam int SAMPLE_LO = -8388608;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h800000;
    localparam logic [SAMPLE_BITS-1:0] BITS_0101 = 24'h555555;
    localparam logic [SAMPLE_BITS-1:0] BITS_1010 = 24'hAAAAAA;

    // Q2.16 coefficient extremes and unity.
    localparam logic [17:0] COEF_MAX = 18'h1FFFF;
    localparam logic [17:0] COEF_MIN = 18'h20000;
    localparam logic [17:0] COEF_ONE = 18'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int STALL_NONE = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    localparam int DRAIN_CYCLES = 4 * CHANNELS + 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int REPORT_LIMIT = 200;
    // Upper bound on the whole simulation, in ns.
    localparam int TIMEOUT_NS = 10_000_000;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] sample_line_t;

    typedef struct packed {
        logic [CHANNELS-1:0][DEV_W-1:0] dev;
        logic [31:0]                    pos;
        logic                           run;
        logic                           cal;
    } line_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [SAMPLE_BITS-1:0] chan0 = '0;
    logic signed [SAMPLE_BITS-1:0] chan1 = '0;
    logic signed [SAMPLE_BITS-1:0] chan2 = '0;
    logic signed [SAMPLE_BITS-1:0] chan3 = '0;
    logic signed [SAMPLE_BITS-1:0] chan4 = '0;
    logic signed [SAMPLE_BITS-1:0] chan5 = '0;
    logic signed [SAMPLE_BITS-1:0] chan6 = '0;
    logic signed [SAMPLE_BITS-1:0] chan7 = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [SAMPLE_BITS:0] dev0, dev1, dev2, dev3, dev4, dev5, dev6, dev7;
    logic signed [31:0] pos_lateral;
    logic run_valid;
    logic calibrating;

    load_cell_position_conditioner #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COEF_FRAC(COEF_FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .chan0(chan0),
        .chan1(chan1),
        .chan2(chan2),
        .chan3(chan3),
        .chan4(chan4),
        .chan5(chan5),
        .chan6(chan6),
        .chan7(chan7),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .dev0(dev0),
        .dev1(dev1),
        .dev2(dev2),
        .dev3(dev3),
        .dev4(dev4),
        .dev5(dev5),
        .dev6(dev6),
        .dev7(dev7),
        .pos_lateral(pos_lateral),
        .run_valid(run_valid),
        .calibrating(calibrating)
    );

    // Register copies, as the block should hold them.
    logic [15:0]        cfg_skip = SKIP_COUNT_RST;
    logic [3:0]         cfg_cal_shift = CAL_SHIFT_RST;
    logic signed [17:0] cfg_b0 = COEFF_B0_RST;
    logic signed [17:0] cfg_b1 = COEFF_B1_RST;
    logic signed [17:0] cfg_a1 = COEFF_A1_RST;
    logic [15:0]        cfg_gain = GAIN_RST;
    logic [30:0]        cfg_deadband = DEADBAND_RST;

    // Conditioner state.
    phase_t      line_phase = PH_SKIP;
    int unsigned line_count = 0;
    longint      baseline_sum [CHANNELS];
    longint      baseline_level [CHANNELS];
    longint      filt_prev_in [CHANNELS];
    longint      filt_prev_out [CHANNELS];
    longint      pos_held = 0;

    line_result_t pending_outputs [$];
    line_result_t got, want;

    int mismatches = 0;
    int lines_checked = 0;
    int lines_skipped = 0;
    int lines_calibrated = 0;
    int lines_filtered = 0;
    int pos_moves = 0;
    int pos_holds = 0;
    int settings_used = 0;
    int hold_left = 0;
    int burst_left = 0;
    int drift_level [CHANNELS];

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results outstanding", pending_outputs.size());
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint round_half_up(longint v, int sh);
        if (sh == 0)
            return v;
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic line_result_t conditioned_outputs(sample_line_t line);
        longint x [CHANNELS];
        longint dev [CHANNELS];
        longint acc, y, diff, p, delta;
        int unsigned s;
        line_result_t r;
        r = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            x[i] = longint'($signed(line[i]));
            dev[i] = 0;
        end

        if (line_phase == PH_SKIP) begin
            r.cal = 1'b1;
            if (line_count >= cfg_skip) begin
                // This line already opens calibration.
                line_phase = PH_CAL;
                line_count = 0;
                for (int i = 0; i < CHANNELS; i++)
                    baseline_sum[i] = 0;
            end else begin
                line_count++;
                lines_skipped++;
            end
        end

        if (line_phase == PH_CAL) begin
            s = (cfg_cal_shift > CAL_SHIFT_MAX) ? CAL_SHIFT_MAX : cfg_cal_shift;
            r.cal = 1'b1;
            lines_calibrated++;
            for (int i = 0; i < CHANNELS; i++)
                baseline_sum[i] += x[i];
            line_count++;
            if (line_count >= (1 << s)) begin
                for (int i = 0; i < CHANNELS; i++) begin
                    baseline_level[i] = round_half_up(baseline_sum[i], s);
                    filt_prev_in[i] = baseline_level[i];
                    filt_prev_out[i] = baseline_level[i];
                end
                line_phase = PH_RUN;
                line_count = 0;
            end
        end else if (line_phase == PH_RUN) begin
            r.run = 1'b1;
            lines_filtered++;
            for (int i = 0; i < CHANNELS; i++) begin
                acc = longint'(cfg_b0) * x[i] + longint'(cfg_b1) * filt_prev_in[i]
                    - longint'(cfg_a1) * filt_prev_out[i];
                y = clamp_signed(round_half_up(acc, COEF_FRAC), 32);
                filt_prev_in[i] = x[i];
                filt_prev_out[i] = y;
                dev[i] = clamp_signed(y - baseline_level[i], DEV_W);
            end
            diff = dev[1] - dev[0];
            p = round_half_up(longint'(cfg_gain) * diff * longint'(POINT_TWO_Q16), POS_FRAC);
            p = clamp_signed(p, 32);
            delta = p - pos_held;
            if (delta < 0)
                delta = -delta;
            if (delta > longint'(cfg_deadband)) begin
                pos_held = p;
                pos_moves++;
            end else begin
                pos_holds++;
            end
            r.pos = 32'(pos_held);
        end

        for (int i = 0; i < CHANNELS; i++)
            r.dev[i] = DEV_W'(dev[i]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int rand_span(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic sample_line_t alt_line(logic [SAMPLE_BITS-1:0] even_val,
                                              logic [SAMPLE_BITS-1:0] odd_val);
        sample_line_t line;
        for (int i = 0; i < CHANNELS; i++)
            line[i] = (i % 2 == 0) ? even_val : odd_val;
        return line;
    endfunction

    // Mostly slow drift with small noise and rare steps, as a real load cell
    // gives; noise_pct of the channels get full-range or extreme values.
    function automatic sample_line_t next_line(int unsigned noise_pct);
        sample_line_t line;
        int v;
        for (int i = 0; i < CHANNELS; i++) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                case ($urandom_range(0, 4))
                    0: line[i] = SAMPLE_MAX;
                    1: line[i] = SAMPLE_MIN;
                    2: line[i] = '0;
                    default: line[i] = SAMPLE_BITS'($urandom);
                endcase
            end else begin
                if ($urandom_range(0, 63) == 0)
                    drift_level[i] = rand_span(3_000_000);
                drift_level[i] += rand_span(2000);
                v = drift_level[i] + rand_span(400);
                if (v > SAMPLE_HI)
                    v = SAMPLE_HI;
                if (v < SAMPLE_LO)
                    v = SAMPLE_LO;
                line[i] = v[SAMPLE_BITS-1:0];
            end
        end
        return line;
    endfunction

    // Bursts of random length separated by random gaps; some bursts run
    // straight into the next one.
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 24);
        return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
    endfunction

    task automatic send_line(input int gap, input sample_line_t line);
        @(negedge clk);
        if (gap > 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        chan0 <= line[0];
        chan1 <= line[1];
        chan2 <= line[2];
        chan3 <= line[3];
        chan4 <= line[4];
        chan5 <= line[5];
        chan6 <= line[6];
        chan7 <= line[7];
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        pending_outputs.push_back(conditioned_outputs(line));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SKIP_COUNT: cfg_skip = data[15:0];
            CFG_CAL_SHIFT:  cfg_cal_shift = data[3:0];
            CFG_COEFF_B0:   cfg_b0 = data[17:0];
            CFG_COEFF_B1:   cfg_b1 = data[17:0];
            CFG_COEFF_A1:   cfg_a1 = data[17:0];
            CFG_GAIN:       cfg_gain = data[15:0];
            CFG_DEADBAND:   cfg_deadband = data[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_filter(input logic [CFG_DATA_W-1:0] b0, b1, a1, g, db);
        write_reg(CFG_COEFF_B0, b0);
        write_reg(CFG_COEFF_B1, b1);
        write_reg(CFG_COEFF_A1, a1);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_DEADBAND, db);
        settings_used++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_deadband();
        case ($urandom_range(0, 2))
            0: return CFG_DATA_W'($urandom_range(0, 4096));
            1: return CFG_DATA_W'($urandom_range(0, 1 << 20));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Full-width random data: the unused upper bits must be ignored. Skip
    // count and averaging shift are rewritten too; past calibration they
    // have no effect.
    task automatic apply_random_filter();
        write_reg(CFG_SKIP_COUNT, CFG_DATA_W'($urandom));
        write_reg(CFG_CAL_SHIFT, CFG_DATA_W'($urandom));
        apply_filter(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom), random_deadband());
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int seg_left;
        int mode;
        int stall_run;
        bit stall;
        seg_left = 0;
        mode = STALL_NONE;
        stall_run = 0;
        forever begin
            @(negedge clk);
            if (seg_left == 0) begin
                mode = $urandom_range(STALL_NONE, STALL_HEAVY);
                seg_left = $urandom_range(40, 300);
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                result_stall <= 1'b1;
            end else begin
                stall = (mode == STALL_LIGHT && $urandom_range(0, 3) == 0)
                     || (mode == STALL_HEAVY && $urandom_range(0, 9) < 6);
                if (stall_run >= 8)
                    stall = 1'b0;
                stall_run = stall ? stall_run + 1 : 0;
                result_stall <= stall;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input longint exp_val,
                                 input longint act_val);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what,
                     exp_val, act_val);
        else if (mismatches == REPORT_LIMIT + 1)
            $display("%0t: further mismatches are counted but not shown", $time);
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            got.dev = {dev7, dev6, dev5, dev4, dev3, dev2, dev1, dev0};
            got.pos = pos_lateral;
            got.run = run_valid;
            got.cal = calibrating;
            if (pending_outputs.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with nothing expected, expected none, got pos %0d",
                         $time, $signed(got.pos));
            end else begin
                want = pending_outputs.pop_front();
                lines_checked++;
                for (int i = 0; i < CHANNELS; i++)
                    if (got.dev[i] !== want.dev[i])
                        note_mismatch($sformatf("line %0d dev%0d", lines_checked, i),
                                      $signed(want.dev[i]), $signed(got.dev[i]));
                if (got.pos !== want.pos)
                    note_mismatch($sformatf("line %0d pos_lateral", lines_checked),
                                  $signed(want.pos), $signed(got.pos));
                if (got.run !== want.run)
                    note_mismatch($sformatf("line %0d run_valid", lines_checked),
                                  want.run, got.run);
                if (got.cal !== want.cal)
                    note_mismatch($sformatf("line %0d calibrating", lines_checked),
                                  want.cal, got.cal);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Skip count at its maximum, then lowered below the lines already skipped.
    task automatic test_skip_phase();
        write_reg(CFG_SKIP_COUNT, 31'd65535);
        write_reg(CFG_CAL_SHIFT, 31'd15);
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        send_line(0, alt_line(SAMPLE_MAX, SAMPLE_MAX));
        send_line(0, alt_line(SAMPLE_MIN, SAMPLE_MIN));
        send_line(next_gap(), alt_line(BITS_0101, BITS_1010));
        wait_idle();
        write_reg(CFG_SKIP_COUNT, 31'd0);
    endtask

    // Averaging shift above the limit, then cut to 2 mid-calibration so that
    // the fourth line closes it.
    task automatic test_calibration();
        sample_line_t line;
        for (int i = 0; i < CHANNELS; i++)
            line[i] = SAMPLE_BITS'((i + 1) * 250000 - 1000000);
        send_line(0, alt_line(SAMPLE_MAX, SAMPLE_MAX));
        send_line(0, alt_line(SAMPLE_MIN, SAMPLE_MIN));
        wait_idle();
        write_reg(CFG_CAL_SHIFT, 31'd2);
        send_line(next_gap(), line);
        for (int i = 0; i < CHANNELS; i++)
            line[i] = SAMPLE_BITS'(rand_span(2_000_000));
        send_line(0, line);
        wait_idle();
    endtask

    task automatic test_run_extremes();
        send_line(0, alt_line('0, '0));
        send_line(0, alt_line(SAMPLE_MAX, SAMPLE_MAX));
        send_line(0, alt_line(SAMPLE_MIN, SAMPLE_MIN));
        send_line(next_gap(), alt_line(SAMPLE_MIN, SAMPLE_MAX));
        send_line(0, alt_line(SAMPLE_MAX, SAMPLE_MIN));
        send_line(0, alt_line(BITS_0101, BITS_1010));
        send_line(0, alt_line(BITS_1010, BITS_0101));
        wait_idle();
        // Unstable filter, full gain and no deadband: everything saturates.
        apply_filter({13'd0, COEF_MAX}, {13'd0, COEF_MIN}, {13'd0, COEF_MIN},
                     31'd65535, 31'd0);
        send_line(0, alt_line(SAMPLE_MAX, SAMPLE_MAX));
        send_line(0, alt_line(SAMPLE_MAX, SAMPLE_MAX));
        send_line(0, alt_line(SAMPLE_MIN, SAMPLE_MAX));
        send_line(0, alt_line(SAMPLE_MIN, SAMPLE_MIN));
        send_line(0, alt_line(SAMPLE_MIN, SAMPLE_MIN));
        wait_idle();
        // Widest deadband: the position moves only on a change above 2^31 - 1.
        write_reg(CFG_DEADBAND, 31'h7FFFFFFF);
        send_line(0, alt_line(SAMPLE_MAX, SAMPLE_MIN));
        send_line(0, alt_line(SAMPLE_MIN, SAMPLE_MAX));
        wait_idle();
    endtask

    task automatic test_tracking();
        apply_filter({13'd0, COEFF_B0_RST}, {13'd0, COEFF_B1_RST}, {13'd0, COEFF_A1_RST},
                     {15'd0, GAIN_RST}, DEADBAND_RST);
        repeat (400)
            send_line(next_gap(), next_line(5));
        wait_idle();
    endtask

    task automatic test_settings_sweep();
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: apply_filter({13'd0, COEFF_B0_RST}, {13'd0, COEFF_B1_RST},
                                {13'd0, COEFF_A1_RST}, 31'd65535, 31'd0);
                1: apply_filter(31'd0, 31'd0, 31'd0, CFG_DATA_W'($urandom),
                                random_deadband());
                2: apply_filter({13'd0, COEF_ONE}, 31'd0, 31'd0, CFG_DATA_W'($urandom),
                                31'h7FFFFFFF);
                3: apply_filter({13'd0, COEF_MAX}, {13'd0, COEF_MIN}, {13'd0, COEF_MIN},
                                CFG_DATA_W'($urandom), random_deadband());
                default: apply_random_filter();
            endcase
            repeat (120)
                send_line(next_gap(), next_line(20));
            wait_idle();
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall the
    // sender, which keeps offering lines back to back.
    task automatic test_backpressure();
        apply_filter({13'd0, COEFF_B0_RST}, {13'd0, COEFF_B1_RST}, {13'd0, COEFF_A1_RST},
                     CFG_DATA_W'($urandom), random_deadband());
        hold_left = HOLD_OFF_CYCLES;
        repeat (20)
            send_line(0, next_line(10));
        wait_idle();
    endtask

    task automatic test_mixed_noise();
        apply_random_filter();
        repeat (250)
            send_line(next_gap(), next_line(60));
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            baseline_sum[i] = 0;
            baseline_level[i] = 0;
            filt_prev_in[i] = 0;
            filt_prev_out[i] = 0;
            drift_level[i] = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_skip_phase();
        test_calibration();
        test_run_extremes();
        test_tracking();
        test_settings_sweep();
        test_backpressure();
        test_mixed_noise();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d lines: %0d skipped, %0d calibration, %0d filtered.",
                 lines_checked, lines_skipped, lines_calibrated, lines_filtered);
        $display("Filter settings applied: %0d; position moved %0d times, held %0d times.",
                 settings_used, pos_moves, pos_holds);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
